// ===== src/sjfs_pkg.sv =====
`default_nettype none

package sjfs_pkg;

	// Default capacity of the process table
	localparam int DefMaxProcs = 16;

	localparam int ArrW  = 16;
	localparam int BurW  = 16;
	localparam int TimeW = 21;
	localparam int PnW   = 5;
	localparam int StepW = 4;

	// Result kinds, carried on m_axis_tuser
	typedef enum logic [1:0] {
		KIND_START    = 2'd0,
		KIND_IDLE     = 2'd1,
		KIND_PROC     = 2'd2,
		KIND_OVERFLOW = 2'd3
	} kind_t;

	// Input command, carried on s_axis_tuser
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	// Datapath operations of one microcode step
	typedef enum logic [2:0] {
		UOP_NONE          = 3'd0,
		UOP_LOAD          = 3'd1,
		UOP_SCAN_MIN_ALL  = 3'd2,
		UOP_SCAN_BEST     = 3'd3,
		UOP_SCAN_MIN_PEND = 3'd4,
		UOP_T_FROM_MIN    = 3'd5,
		UOP_ADVANCE       = 3'd6,
		UOP_CLEAR         = 3'd7
	} uop_t;

	// Source of the result time
	typedef enum logic [1:0] {
		TSRC_ZERO = 2'd0,
		TSRC_MIN  = 2'd1,
		TSRC_SUM  = 2'd2
	} tsrc_t;

	// Source of the last flag
	typedef enum logic [1:0] {
		LAST_NO   = 2'd0,
		LAST_YES  = 2'd1,
		LAST_DONE = 2'd2
	} lsrc_t;

	// Jump conditions: jump to target when true, else fall through; COND_WAIT holds while no transfer
	typedef enum logic [2:0] {
		COND_NEXT      = 3'd0,
		COND_ALWAYS    = 3'd1,
		COND_WAIT      = 3'd2,
		COND_NOT_FULL  = 3'd3,
		COND_NOT_EMPTY = 3'd4,
		COND_SCAN_BUSY = 3'd5,
		COND_FOUND     = 3'd6,
		COND_MORE      = 3'd7
	} cond_t;

	typedef struct packed {
		uop_t              op;
		logic              emit;
		kind_t             kind;
		tsrc_t             tsrc;
		lsrc_t             lsrc;
		cond_t             cond;
		logic [StepW-1:0]  target;
	} ucode_t;

	// Program step labels
	localparam logic [StepW-1:0] ST_WAIT       = 4'd0;
	localparam logic [StepW-1:0] ST_LOAD       = 4'd1;
	localparam logic [StepW-1:0] ST_OVERFLOW   = 4'd2;
	localparam logic [StepW-1:0] ST_RUN        = 4'd3;
	localparam logic [StepW-1:0] ST_EMPTY      = 4'd4;
	localparam logic [StepW-1:0] ST_SCAN_FIRST = 4'd5;
	localparam logic [StepW-1:0] ST_START      = 4'd6;
	localparam logic [StepW-1:0] ST_SCAN_BEST  = 4'd7;
	localparam logic [StepW-1:0] ST_CHECK      = 4'd8;
	localparam logic [StepW-1:0] ST_SCAN_NEXT  = 4'd9;
	localparam logic [StepW-1:0] ST_IDLE       = 4'd10;
	localparam logic [StepW-1:0] ST_DISPATCH   = 4'd11;
	localparam logic [StepW-1:0] ST_CLEAR      = 4'd12;

	// Control store
	function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
		ucode_t w;
		w = '{op: UOP_NONE, emit: 1'b0, kind: KIND_START, tsrc: TSRC_ZERO,
		      lsrc: LAST_NO, cond: COND_ALWAYS, target: ST_WAIT};
		case (step)
			ST_WAIT: begin
				w.cond   = COND_WAIT;
				w.target = ST_RUN;
			end
			ST_LOAD: begin
				w.op     = UOP_LOAD;
				w.cond   = COND_NOT_FULL;
				w.target = ST_WAIT;
			end
			ST_OVERFLOW: begin
				w.emit = 1'b1;
				w.kind = KIND_OVERFLOW;
			end
			ST_RUN: begin
				w.cond   = COND_NOT_EMPTY;
				w.target = ST_SCAN_FIRST;
			end
			ST_EMPTY: begin
				w.emit = 1'b1;
				w.lsrc = LAST_YES;
			end
			ST_SCAN_FIRST: begin
				w.op     = UOP_SCAN_MIN_ALL;
				w.cond   = COND_SCAN_BUSY;
				w.target = ST_SCAN_FIRST;
			end
			ST_START: begin
				w.op   = UOP_T_FROM_MIN;
				w.emit = 1'b1;
				w.tsrc = TSRC_MIN;
				w.cond = COND_NEXT;
			end
			ST_SCAN_BEST: begin
				w.op     = UOP_SCAN_BEST;
				w.cond   = COND_SCAN_BUSY;
				w.target = ST_SCAN_BEST;
			end
			ST_CHECK: begin
				w.cond   = COND_FOUND;
				w.target = ST_DISPATCH;
			end
			ST_SCAN_NEXT: begin
				w.op     = UOP_SCAN_MIN_PEND;
				w.cond   = COND_SCAN_BUSY;
				w.target = ST_SCAN_NEXT;
			end
			ST_IDLE: begin
				w.op     = UOP_T_FROM_MIN;
				w.emit   = 1'b1;
				w.kind   = KIND_IDLE;
				w.tsrc   = TSRC_MIN;
				w.target = ST_SCAN_BEST;
			end
			ST_DISPATCH: begin
				w.op     = UOP_ADVANCE;
				w.emit   = 1'b1;
				w.kind   = KIND_PROC;
				w.tsrc   = TSRC_SUM;
				w.lsrc   = LAST_DONE;
				w.cond   = COND_MORE;
				w.target = ST_SCAN_BEST;
			end
			ST_CLEAR: begin
				w.op = UOP_CLEAR;
			end
			default: begin
				w.target = ST_WAIT;
			end
		endcase
		return w;
	endfunction

	// Control of the process store
	typedef struct packed {
		logic wr;
		logic clr_one;
		logic clr_all;
	} store_ctl_t;

	// Registered read of one store entry
	typedef struct packed {
		logic            pend;
		logic [ArrW-1:0] arr;
		logic [BurW-1:0] bur;
	} store_rd_t;

endpackage

`default_nettype wire

// ===== src/sjfs_store.sv =====
`default_nettype none

module sjfs_store import sjfs_pkg::*; #(
	parameter int MAX_PROCS = DefMaxProcs,
	localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire store_ctl_t      ctl,
	input  wire logic [IW-1:0]   wr_addr,
	input  wire logic [ArrW-1:0] wr_arr,
	input  wire logic [BurW-1:0] wr_bur,
	input  wire logic [IW-1:0]   clr_addr,
	input  wire logic [IW-1:0]   rd_addr,
	output store_rd_t            rd
);

	logic [ArrW-1:0] arr_mem [MAX_PROCS];
	logic [BurW-1:0] bur_mem [MAX_PROCS];
	logic [MAX_PROCS-1:0] pend_q;
	store_rd_t rd_q;

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			arr_mem[wr_addr] <= wr_arr;
			bur_mem[wr_addr] <= wr_bur;
		end
		rd_q.arr <= arr_mem[rd_addr];
		rd_q.bur <= bur_mem[rd_addr];
		rd_q.pend <= pend_q[rd_addr];
	end

	// Pending flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (ctl.clr_all) begin
			pend_q <= '0;
		end else begin
			if (ctl.wr)
				pend_q[wr_addr] <= 1'b1;
			if (ctl.clr_one)
				pend_q[clr_addr] <= 1'b0;
		end
	end

	assign rd = rd_q;

endmodule

`default_nettype wire

// ===== src/sjf_nonpreemptive_scheduler_unit.sv =====
`default_nettype none

// Non-preemptive shortest-job-first scheduler. A load transfer (tuser 0) stores one process
// (arrival, burst) in a table of MAX_PROCS entries and gives no result; a load into a full table
// is dropped and gives one overflow result. A run transfer (tuser 1) gives a start result with the
// earliest arrival, then for each dispatch an optional idle result (ending at the next arrival) and
// a process result with its number and completion time; tlast marks the final result, after which
// the table is empty again. A run on an empty table gives only a start result of time zero with
// tlast. Control is a microcoded sequencer stepping over one memory read port; it stalls on a
// result step while a result is held and m_axis_tready is low.
module sjf_nonpreemptive_scheduler_unit import sjfs_pkg::*; #(
	parameter int MAX_PROCS = DefMaxProcs
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // arrival_time[15:0], burst_time[31:16]
	input  wire logic [0:0]  s_axis_tuser,  // command[0]
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [31:0] m_axis_tdata,  // process_number[4:0], time_value[25:5], zero fill
	output      logic [1:0]  m_axis_tuser,  // kind[1:0]
	output      logic        m_axis_tlast
);

	localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CW  = $clog2(MAX_PROCS + 1);
	localparam int PSW = (IW + 1 > PnW) ? IW + 1 : PnW;
	localparam logic [CW-1:0] CapCnt = CW'(MAX_PROCS);

	// Sequencer state
	logic [StepW-1:0] step_q, step_d;
	ucode_t uw;
	logic in_xfer, stall, step_go, take, hold, is_scan;

	// Datapath registers
	logic [CW-1:0]    count_q, done_q, sc_q, done_inc;
	logic [ArrW-1:0]  arr_in_q, bur_in_q, min_q;
	logic [TimeW-1:0] t_q, t_sum;
	logic [IW-1:0]    best_q, idx_s1;
	logic [BurW-1:0]  best_bur_q;
	logic [ArrW-1:0]  best_arr_q;
	logic             found_q, vld_s1;
	logic [PSW-1:0]   pn_full;

	// Output register
	logic             out_valid_q, out_last_q;
	kind_t            out_kind_q;
	logic [PnW-1:0]   out_pn_q;
	logic [TimeW-1:0] out_time_q;

	store_ctl_t st_ctl;
	store_rd_t  st_rd;

	sjfs_store #(.MAX_PROCS(MAX_PROCS)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (st_ctl),
		.wr_addr  (count_q[IW-1:0]),
		.wr_arr   (arr_in_q),
		.wr_bur   (bur_in_q),
		.clr_addr (best_q),
		.rd_addr  (sc_q[IW-1:0]),
		.rd       (st_rd)
	);

	// Control word decode and next step
	always_comb begin
		uw       = ucode_rom(step_q);
		in_xfer  = s_axis_tvalid && s_axis_tready;
		stall    = uw.emit && out_valid_q && !m_axis_tready;
		step_go  = !stall;
		done_inc = done_q + CW'(1);
		is_scan  = (uw.op == UOP_SCAN_MIN_ALL) || (uw.op == UOP_SCAN_BEST) ||
		           (uw.op == UOP_SCAN_MIN_PEND);
		take = 1'b0;
		hold = 1'b0;
		case (uw.cond)
			COND_NEXT:      take = 1'b0;
			COND_ALWAYS:    take = 1'b1;
			COND_WAIT: begin
				hold = !in_xfer;
				take = in_xfer && (s_axis_tuser[0] == CMD_RUN);
			end
			COND_NOT_FULL:  take = (count_q < CapCnt);
			COND_NOT_EMPTY: take = (count_q != '0);
			COND_SCAN_BUSY: take = (sc_q != count_q);
			COND_FOUND:     take = found_q;
			COND_MORE:      take = (done_inc != count_q);
			default:        take = 1'b0;
		endcase
		if (stall)
			step_d = step_q;
		else if (hold)
			step_d = step_q;
		else if (take)
			step_d = uw.target;
		else
			step_d = step_q + StepW'(1);
	end

	assign s_axis_tready = (step_q == ST_WAIT);

	// Store control
	always_comb begin
		st_ctl.wr      = (uw.op == UOP_LOAD) && (count_q < CapCnt);
		st_ctl.clr_one = (uw.op == UOP_ADVANCE) && step_go;
		st_ctl.clr_all = (uw.op == UOP_CLEAR);
	end

	// Result fields
	assign t_sum   = t_q + TimeW'(best_bur_q);
	assign pn_full = PSW'(best_q) + PSW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			arr_in_q <= s_axis_tdata[15:0];
			bur_in_q <= s_axis_tdata[31:16];
		end
	end

	// Scan read pipeline: entry index travels with the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q   <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= is_scan && (sc_q != count_q);
			if (is_scan)
				sc_q <= (sc_q == count_q) ? '0 : sc_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= sc_q[IW-1:0];
	end

	// Scan accumulators
	always_ff @(posedge clk) begin
		if (is_scan && (sc_q == '0)) begin
			min_q <= '1;
		end else if (vld_s1 && (uw.op == UOP_SCAN_MIN_ALL)) begin
			if (st_rd.arr < min_q)
				min_q <= st_rd.arr;
		end else if (vld_s1 && (uw.op == UOP_SCAN_MIN_PEND)) begin
			if (st_rd.pend && (st_rd.arr < min_q))
				min_q <= st_rd.arr;
		end
		if (vld_s1 && (uw.op == UOP_SCAN_BEST) && st_rd.pend &&
		    (TimeW'(st_rd.arr) <= t_q)) begin
			if (!found_q || (st_rd.bur < best_bur_q) ||
			    ((st_rd.bur == best_bur_q) && (st_rd.arr < best_arr_q))) begin
				best_q     <= idx_s1;
				best_bur_q <= st_rd.bur;
				best_arr_q <= st_rd.arr;
			end
		end
	end

	// Control registers of the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= '0;
			t_q     <= '0;
			found_q <= 1'b0;
		end else begin
			if (is_scan && (sc_q == '0))
				found_q <= 1'b0;
			else if (vld_s1 && (uw.op == UOP_SCAN_BEST) && st_rd.pend &&
			         (TimeW'(st_rd.arr) <= t_q))
				found_q <= 1'b1;
			if (step_go) begin
				case (uw.op)
					UOP_LOAD: begin
						if (count_q < CapCnt)
							count_q <= count_q + CW'(1);
					end
					UOP_T_FROM_MIN: t_q <= TimeW'(min_q);
					UOP_ADVANCE: begin
						t_q    <= t_sum;
						done_q <= done_inc;
					end
					UOP_CLEAR: begin
						count_q <= '0;
						done_q  <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.emit && step_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.emit && step_go) begin
			out_kind_q <= uw.kind;
			out_pn_q   <= (uw.kind == KIND_PROC) ? pn_full[PnW-1:0] : '0;
			case (uw.tsrc)
				TSRC_MIN: out_time_q <= TimeW'(min_q);
				TSRC_SUM: out_time_q <= t_sum;
				default:  out_time_q <= '0;
			endcase
			case (uw.lsrc)
				LAST_YES:  out_last_q <= 1'b1;
				LAST_DONE: out_last_q <= (done_inc == count_q);
				default:   out_last_q <= 1'b0;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_time_q, out_pn_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	// Checks
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CapCnt)
		else $error("stored process count beyond capacity");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		is_scan |-> (sc_q <= count_q))
		else $error("scan index ran past the stored processes");

	a_dispatch_found: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_DISPATCH) |-> found_q)
		else $error("dispatch without an eligible process");

	a_idle_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_IDLE) |-> (TimeW'(min_q) > t_q))
		else $error("idle gap does not move time forward");

endmodule

`default_nettype wire
